### src/tpfs_pkg.sv
// shared types and constants of the timed pixel fade scheduler
`default_nettype none
package tpfs_pkg;

  localparam int MAX_PROGRAMS = 8;
  localparam int SLOT_W       = $clog2(MAX_PROGRAMS);
  localparam int CNT_W        = 4;
  localparam int HHMM_SCALE   = 100;
  localparam int CFG_DATA_W   = 14;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic CFG_PROGRAM_COUNT = 1'b0;
  localparam logic CFG_PIXEL_OFFSET  = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_BLUE  = 2'd1;
  localparam logic [1:0] CH_WHITE = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  slot;
    logic [11:0] start_hhmm;
    logic [11:0] end_hhmm;
    logic [7:0]  start_red;
    logic [7:0]  start_blue;
    logic [7:0]  start_white;
    logic [7:0]  end_red;
    logic [7:0]  end_blue;
    logic [7:0]  end_white;
    logic [17:0] time_hhmmss;
    logic [7:0]  pixel_index;
  } in_t;

  typedef struct packed {
    logic [23:0] packed_color;
    logic        matched;
    logic [2:0]  matched_slot;
  } out_t;

  // one program slot: window ends in hhmmss, start levels and signed deltas per channel
  typedef struct packed {
    logic [18:0]       ws;
    logic [18:0]       we;
    logic [2:0][7:0]   lvl;
    logic [2:0][8:0]   dlt;
  } entry_t;

endpackage
`default_nettype wire

### src/tpfs_table.sv
// program slot storage with one write port and one registered read port
`default_nettype none
module tpfs_table
  import tpfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire in_t               wr,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output entry_t                 rd_data
);

  entry_t mem [MAX_PROGRAMS];
  entry_t wr_entry;

  always_comb begin
    wr_entry.ws     = 19'({7'b0, wr.start_hhmm} * 19'(HHMM_SCALE));
    wr_entry.we     = 19'({7'b0, wr.end_hhmm} * 19'(HHMM_SCALE));
    wr_entry.lvl[CH_RED]   = wr.start_red;
    wr_entry.lvl[CH_BLUE]  = wr.start_blue;
    wr_entry.lvl[CH_WHITE] = wr.start_white;
    wr_entry.dlt[CH_RED]   = {1'b0, wr.end_red} - {1'b0, wr.start_red};
    wr_entry.dlt[CH_BLUE]  = {1'b0, wr.end_blue} - {1'b0, wr.start_blue};
    wr_entry.dlt[CH_WHITE] = {1'b0, wr.end_white} - {1'b0, wr.start_white};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr.slot[SLOT_W-1:0]] <= wr_entry;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### src/tpfs_div.sv
// restoring divider, eight quotient bits, one bit per cycle
`default_nettype none
module tpfs_div
  import tpfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [25:0] dividend,
  input  wire logic [18:0] divisor,
  output logic             done,
  output logic [7:0]       quo,
  output logic             rem_nz
);

  logic        busy;
  logic [2:0]  step;
  logic [25:0] rem;
  logic [25:0] dsr;

  // dividend is known to be below 256 times the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend;
        dsr  <= {divisor, 7'b0};
        quo  <= '0;
        step <= 3'd7;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsr) begin
          rem <= rem - dsr;
          quo <= {quo[6:0], 1'b1};
        end else begin
          quo <= {quo[6:0], 1'b0};
        end
        dsr <= dsr >> 1;
        if (step == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 3'd1;
        end
      end
    end
  end

  assign rem_nz = (rem != '0);

endmodule
`default_nettype wire

### src/timed_pixel_fade_scheduler.sv
// top level: sequencer for slot search and per-channel fade division
//
// Input channel in_valid / in_stall / in_data carries load and evaluate items;
// a transfer happens when in_valid is high and in_stall is low.
// A load writes one program slot in the transfer cycle and gives no result;
// the next item can follow in the next cycle.
// An evaluate then runs through these steps: the pixel shift is applied, the
// table is searched, the winner is fetched, per channel a multiply, a divider
// start, the divider steps and taking the quotient follow, and the result is
// registered. No match skips the fetch and the division, and an empty window
// skips the division.
// in_stall stays high for the whole evaluation.
// The result goes to an output register out_valid / out_stall / out_data;
// while it waits under out_stall a new item is still taken, and a finished
// evaluation waits until the output register is free.
// cfg_we writes program_count (index 0) or pixel_offset (index 1) from
// cfg_data; write only while idle.
// Synchronous rst clears the sequencer, the output valid and both
// configuration registers; slot contents are undefined until loaded.
`default_nettype none
module timed_pixel_fade_scheduler
  import tpfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    IDLE, SHIFT, ADJ, SCAN, FETCH, PREP, MUL, DIVS, DIVW, FINISH
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  program_count;
  logic [13:0]       pixel_offset;
  logic [CNT_W-1:0]  count_eff;

  logic [17:0]        t;
  logic [7:0]         pix;
  logic [21:0]        shift;
  logic [17:0]        tt;
  logic [CNT_W-1:0]   scan_idx;
  logic               chk_vld;
  logic [SLOT_W-1:0]  chk_idx;
  logic               hit;
  logic [SLOT_W-1:0]  win;
  logic [17:0]        elapsed;
  logic [18:0]        span;
  logic [1:0]         ch;
  logic signed [27:0] num;
  logic [2:0][7:0]    lvl_out;

  logic              accept;
  logic              tbl_we;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              match;
  logic [25:0]       num_mag;
  logic              div_start;
  logic              div_done;
  logic [7:0]        div_quo;
  logic              div_rem_nz;
  logic [7:0]        st_lvl;
  logic [7:0]        faded;

  assign in_stall  = (state != IDLE);
  assign accept    = in_valid && !in_stall;
  assign tbl_we    = accept && (in_data.opcode == OP_LOAD);
  assign count_eff = ({1'b0, program_count} > (CNT_W+1)'(MAX_PROGRAMS))
                     ? CNT_W'(MAX_PROGRAMS) : program_count;
  assign rd_addr   = (state == SCAN) ? scan_idx[SLOT_W-1:0] : win;
  assign match     = (rd_data.ws <= {1'b0, tt}) && ({1'b0, tt} <= rd_data.we);
  assign num_mag   = num[27] ? 26'(-num) : 26'(num);
  assign div_start = (state == DIVS) && (span != '0);
  assign st_lvl    = rd_data.lvl[ch];
  // floor toward minus infinity for a negative fade
  assign faded     = num[27] ? 8'(st_lvl - div_quo - {7'b0, div_rem_nz})
                             : 8'(st_lvl + div_quo);

  tpfs_table u_table (
    .clk     (clk),
    .we      (tbl_we),
    .wr      (in_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tpfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_mag),
    .divisor  (span),
    .done     (div_done),
    .quo      (div_quo),
    .rem_nz   (div_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      program_count <= '0;
      pixel_offset  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROGRAM_COUNT: program_count <= cfg_data[CNT_W-1:0];
        CFG_PIXEL_OFFSET:  pixel_offset  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      chk_vld   <= 1'b0;
      hit       <= 1'b0;
    end else begin
      // in FINISH the output register is refilled below
      if (out_valid && !out_stall && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && (in_data.opcode == OP_EVAL)) begin
            t     <= in_data.time_hhmmss;
            pix   <= in_data.pixel_index;
            hit   <= 1'b0;
            win   <= '0;
            state <= SHIFT;
          end
        end
        SHIFT: begin
          shift <= 22'(pixel_offset) * 22'(pix);
          state <= ADJ;
        end
        ADJ: begin
          // work in window coordinates: compare against time minus shift
          tt       <= 18'({4'b0, t} - shift);
          scan_idx <= '0;
          chk_vld  <= 1'b0;
          if ({4'b0, t} >= shift) begin
            state <= SCAN;
          end else begin
            state <= FINISH;
          end
        end
        SCAN: begin
          if (chk_vld && match) begin
            hit <= 1'b1;
            win <= chk_idx;
          end
          if (scan_idx != count_eff) begin
            chk_vld  <= 1'b1;
            chk_idx  <= scan_idx[SLOT_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
          end else begin
            chk_vld <= 1'b0;
            state   <= (hit || (chk_vld && match)) ? FETCH : FINISH;
          end
        end
        FETCH: begin
          state <= PREP;
        end
        PREP: begin
          elapsed <= 18'({1'b0, tt} - rd_data.ws);
          span    <= rd_data.we - rd_data.ws;
          ch      <= CH_RED;
          state   <= MUL;
        end
        MUL: begin
          num   <= 28'($signed(rd_data.dlt[ch])) * 28'($signed({1'b0, elapsed}));
          state <= DIVS;
        end
        DIVS: begin
          if (span == '0) begin
            lvl_out[ch] <= st_lvl;
            if (ch == CH_WHITE) begin
              state <= FINISH;
            end else begin
              ch    <= ch + 2'd1;
              state <= MUL;
            end
          end else begin
            state <= DIVW;
          end
        end
        DIVW: begin
          if (div_done) begin
            lvl_out[ch] <= faded;
            if (ch == CH_WHITE) begin
              state <= FINISH;
            end else begin
              ch    <= ch + 2'd1;
              state <= MUL;
            end
          end
        end
        FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data.matched <= hit;
            if (hit) begin
              out_data.packed_color <= {lvl_out[CH_BLUE], lvl_out[CH_RED], lvl_out[CH_WHITE]};
              out_data.matched_slot <= 3'(win);
            end else begin
              out_data.packed_color <= '0;
              out_data.matched_slot <= '0;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // no match always reports black and slot zero
  a_nomatch_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.matched |-> out_data.packed_color == '0 && out_data.matched_slot == '0)
    else $error("unmatched result carries color or slot");

  // an evaluate holds off the input channel in the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.opcode == OP_EVAL |=> in_stall)
    else $error("evaluate did not occupy the sequencer");

  // a load completes in its transfer cycle
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.opcode == OP_LOAD |=> !in_stall)
    else $error("load left the sequencer busy");

  // a waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("pending result changed under stall");

endmodule
`default_nettype wire
